FILE: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, register indexes and constants for the echo ranger block.
// ----------------------------------------------------------------------------
package uer_pkg;

   // Default counter widths.
   localparam int DEFAULT_TICK_COUNTER_WIDTH = 24;
   localparam int DEFAULT_ECHO_COUNTER_WIDTH = 16;

   // Configuration register widths.
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register reset values.
   localparam logic [23:0] SETTLE_TICKS_RESET  = 24'd60000;
   localparam logic [9:0]  PULSE_TICKS_RESET   = 10'd10;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd30000;
   localparam logic [23:0] HOLD_TICKS_RESET    = 24'd1000000;
   localparam logic [15:0] MIN_DISTANCE_RESET  = 16'd200;
   localparam logic [15:0] MAX_DISTANCE_RESET  = 16'd40000;

   // Trigger low gap before the pulse, in ticks.
   localparam int LOW_GAP_TICKS = 2;

   // Distance per echo tick is SOUND_NUM / SOUND_DEN hundredths of a centimetre.
   // The running quotient and remainder advance by the whole and fractional
   // parts of that ratio on every counted tick.
   localparam int SOUND_NUM   = 343;
   localparam int SOUND_DEN   = 200;
   localparam int SOUND_WHOLE = SOUND_NUM / SOUND_DEN;
   localparam int SOUND_FRAC  = SOUND_NUM % SOUND_DEN;
   localparam int REM_WIDTH   = $clog2(SOUND_DEN);

   localparam logic [15:0] DISTANCE_SATURATE = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_SETTLE     = 3'd0,
      PH_TRIG_LOW   = 3'd1,
      PH_TRIG_HIGH  = 3'd2,
      PH_WAIT_RISE  = 3'd3,
      PH_COUNT_HIGH = 3'd4,
      PH_HOLD       = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_IN_RANGE     = 2'd0,
      STATUS_OUT_OF_RANGE = 2'd1,
      STATUS_NO_RISE      = 2'd2,
      STATUS_ECHO_LONG    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SETTLE_TICKS  = 3'd0,
      CSR_PULSE_TICKS   = 3'd1,
      CSR_TIMEOUT_TICKS = 3'd2,
      CSR_HOLD_TICKS    = 3'd3,
      CSR_MIN_DISTANCE  = 3'd4,
      CSR_MAX_DISTANCE  = 3'd5
   } csr_index_type;

endpackage

FILE: hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Tick-driven sequencer that triggers an ultrasonic sensor, times the echo
// and reports distance, status and attempt count.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req_ channel is one microsecond tick carrying the
// sampled echo level and the run enable. Every accepted tick produces exactly
// one transfer on the rsp_ channel, carrying the trigger level for that tick
// and, on the tick an attempt ends, a result flagged by rsp_result_valid.
// The block takes one tick per cycle while the receiver does not stall: the
// sequencer state and the response register are updated together at the
// accepting edge, so the response appears in the cycle after the tick is
// accepted and a new tick can be accepted in every such cycle. The single
// response register is refilled in the same cycle that the receiver takes
// it, so only a stall on rsp_ holds up req_. While the receiver stalls, the
// response holds and req_stall is raised; no tick is lost or repeated.
// Reset returns the sequencer to the settle phase with all counters cleared
// and loads the default configuration: 60000 settle ticks, a 10 tick pulse,
// 30000 tick edge timeout, 1000000 hold ticks and a range of 2 cm to 400 cm.
// The csr_ port writes one register per cycle and should only be used while
// no ticks are in flight.
// The distance is kept as a running quotient and remainder of
// echo_ticks * 343 / 200, so no multiplier or divider is needed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = DEFAULT_TICK_COUNTER_WIDTH,
   parameter int ECHO_COUNTER_WIDTH = DEFAULT_ECHO_COUNTER_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // Tick input channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_echo_level,
   input  logic                       req_run_enable,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_trigger_level,
   output logic                       rsp_result_valid,
   output logic [15:0]                rsp_distance_centi_cm,
   output logic [1:0]                 rsp_status,
   output logic [15:0]                rsp_attempt_count,
   // Configuration write port.
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int TW = TICK_COUNTER_WIDTH;
   localparam int EW = ECHO_COUNTER_WIDTH;
   // The quotient stays below twice the echo count.
   localparam int QW = EW + 1;
   // Compare widths wide enough for both operands.
   localparam int CW  = (TW > 24) ? TW : 24;
   localparam int EXW = (EW > 16) ? EW : 16;
   localparam int MW  = (QW > 16) ? QW : 16;

   localparam logic [TW-1:0] TICK_MAX = '1;
   localparam logic [EW-1:0] ECHO_MAX = '1;

   // Configuration registers.
   logic [23:0] settle_ticks_ff;
   logic [9:0]  pulse_ticks_ff;
   logic [15:0] timeout_ticks_ff;
   logic [23:0] hold_ticks_ff;
   logic [15:0] min_distance_ff;
   logic [15:0] max_distance_ff;

   // Sequencer state.
   phase_type              phase_ff, phase_in;
   logic [TW-1:0]          phase_ticks_ff, phase_ticks_in;
   logic [EW-1:0]          echo_ticks_ff, echo_ticks_in;
   logic [QW-1:0]          dist_q_ff, dist_q_in;
   logic [REM_WIDTH-1:0]   dist_r_ff, dist_r_in;
   logic [15:0]            attempts_ff, attempts_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_trigger_level_ff, rsp_trigger_level_in;
   logic                   rsp_result_valid_ff, rsp_result_valid_in;
   logic [15:0]            rsp_distance_ff, rsp_distance_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [15:0]            rsp_attempt_count_ff;

   // Shared decisions.
   logic                   req_accept;
   logic [TW-1:0]          tick_inc;
   logic [CW-1:0]          tick_limit;
   logic                   tick_done;
   logic                   rise_expired;
   logic                   echo_expired;
   logic                   rise_timeout;
   logic [REM_WIDTH:0]     rem_sum;
   logic                   rem_carry;
   logic [MW-1:0]          dist_q_ext;
   logic [15:0]            dist_sat;
   logic                   dist_in_range;

   // ------------------------------------------------------------------------
   // Handshake: a tick is taken whenever the response register is empty or
   // is being emptied in the same cycle.
   // ------------------------------------------------------------------------
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff  <= SETTLE_TICKS_RESET;
         pulse_ticks_ff   <= PULSE_TICKS_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
         hold_ticks_ff    <= HOLD_TICKS_RESET;
         min_distance_ff  <= MIN_DISTANCE_RESET;
         max_distance_ff  <= MAX_DISTANCE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SETTLE_TICKS:  settle_ticks_ff  <= csr_write_data[23:0];
            CSR_PULSE_TICKS:   pulse_ticks_ff   <= csr_write_data[9:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_write_data[15:0];
            CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_write_data[23:0];
            CSR_MIN_DISTANCE:  min_distance_ff  <= csr_write_data[15:0];
            CSR_MAX_DISTANCE:  max_distance_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Shared conditions.
   // ------------------------------------------------------------------------
   // The phase tick counter saturates instead of wrapping.
   assign tick_inc = (phase_ticks_ff == TICK_MAX) ? phase_ticks_ff
                                                   : phase_ticks_ff + 1'b1;

   // Limit of the timed phases; the settle phase uses its own register.
   always_comb begin
      case (phase_ff)
         PH_TRIG_LOW:  tick_limit = CW'(LOW_GAP_TICKS);
         PH_TRIG_HIGH: tick_limit = CW'(pulse_ticks_ff);
         PH_HOLD:      tick_limit = CW'(hold_ticks_ff);
         default:      tick_limit = CW'(settle_ticks_ff);
      endcase
   end

   // A timed phase ends when its limit is reached or its counter saturates.
   // A zero limit therefore behaves as one tick.
   assign tick_done = (CW'(tick_inc) >= tick_limit) || (tick_inc == TICK_MAX);

   // Waiting for the echo to rise has run out of polls.
   assign rise_expired = (CW'(phase_ticks_ff) >= CW'(timeout_ticks_ff))
                         || (phase_ticks_ff == TICK_MAX);

   // The echo has stayed high for the whole timeout.
   assign echo_expired = (EXW'(echo_ticks_ff) >= EXW'(timeout_ticks_ff))
                         || (echo_ticks_ff == ECHO_MAX);

   // The rising tick is itself the first poll: only a zero timeout fails it.
   assign rise_timeout = (timeout_ticks_ff == 16'd0);

   // Running quotient and remainder of echo_ticks * 343 / 200.
   assign rem_sum   = (REM_WIDTH + 1)'(dist_r_ff) + (REM_WIDTH + 1)'(SOUND_FRAC);
   assign rem_carry = (rem_sum >= (REM_WIDTH + 1)'(SOUND_DEN));

   // Saturate the distance to 16 bits.
   assign dist_q_ext = MW'(dist_q_ff);
   assign dist_sat   = (dist_q_ext > MW'(DISTANCE_SATURATE)) ? DISTANCE_SATURATE
                                                             : dist_q_ext[15:0];

   // The exact product is q * 200 + r with r below 200, so the low bound is a
   // plain quotient compare and the high bound also needs a zero remainder
   // when the quotient equals it.
   assign dist_in_range = (dist_q_ext >= MW'(min_distance_ff))
                          && ((dist_q_ext < MW'(max_distance_ff))
                              || ((dist_q_ext == MW'(max_distance_ff))
                                  && (dist_r_ff == '0)));

   // ------------------------------------------------------------------------
   // Next phase.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TRIG_LOW: begin
            if (tick_done) phase_in = PH_TRIG_HIGH;
         end
         PH_TRIG_HIGH: begin
            if (tick_done) phase_in = PH_WAIT_RISE;
         end
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               phase_in = rise_timeout ? PH_SETTLE : PH_COUNT_HIGH;
            end else if (rise_expired) begin
               phase_in = PH_SETTLE;
            end
         end
         PH_COUNT_HIGH: begin
            if (req_echo_level) begin
               if (echo_expired) phase_in = PH_SETTLE;
            end else begin
               phase_in = PH_HOLD;
            end
         end
         PH_HOLD: begin
            if (tick_done) phase_in = PH_SETTLE;
         end
         default: begin
            if (req_run_enable && tick_done) phase_in = PH_TRIG_LOW;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Counters.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      echo_ticks_in  = echo_ticks_ff;
      dist_q_in      = dist_q_ff;
      dist_r_in      = dist_r_ff;
      attempts_in    = attempts_ff;
      case (phase_ff)
         PH_TRIG_LOW, PH_TRIG_HIGH, PH_HOLD: begin
            phase_ticks_in = tick_done ? '0 : tick_inc;
         end
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               // The rising tick counts as the first high tick.
               phase_ticks_in = '0;
               echo_ticks_in  = rise_timeout ? '0 : EW'(1);
               dist_q_in      = QW'(SOUND_WHOLE);
               dist_r_in      = REM_WIDTH'(SOUND_FRAC);
            end else if (rise_expired) begin
               phase_ticks_in = '0;
            end else begin
               phase_ticks_in = tick_inc;
            end
         end
         PH_COUNT_HIGH: begin
            phase_ticks_in = '0;
            if (req_echo_level && !echo_expired) begin
               echo_ticks_in = echo_ticks_ff + 1'b1;
               if (rem_carry) begin
                  dist_q_in = dist_q_ff + QW'(SOUND_WHOLE + 1);
                  dist_r_in = REM_WIDTH'(rem_sum - (REM_WIDTH + 1)'(SOUND_DEN));
               end else begin
                  dist_q_in = dist_q_ff + QW'(SOUND_WHOLE);
                  dist_r_in = rem_sum[REM_WIDTH-1:0];
               end
            end
         end
         default: begin
            // Settling: a low run enable restarts the settle count.
            if (!req_run_enable || tick_done) begin
               phase_ticks_in = '0;
            end else begin
               phase_ticks_in = tick_inc;
            end
            if (req_run_enable && tick_done) begin
               attempts_in = attempts_ff + 16'd1;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Response for this tick.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_trigger_level_in = (phase_ff == PH_TRIG_HIGH);
      rsp_result_valid_in  = 1'b0;
      rsp_distance_in      = 16'd0;
      rsp_status_in        = STATUS_IN_RANGE;
      unique case (phase_ff)
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               if (rise_timeout) begin
                  rsp_result_valid_in = 1'b1;
                  rsp_status_in       = STATUS_ECHO_LONG;
               end
            end else if (rise_expired) begin
               rsp_result_valid_in = 1'b1;
               rsp_status_in       = STATUS_NO_RISE;
            end
         end
         PH_COUNT_HIGH: begin
            if (req_echo_level) begin
               if (echo_expired) begin
                  rsp_result_valid_in = 1'b1;
                  rsp_status_in       = STATUS_ECHO_LONG;
               end
            end else begin
               // The falling tick ends the measurement without being counted.
               rsp_result_valid_in = 1'b1;
               rsp_distance_in     = dist_sat;
               rsp_status_in       = dist_in_range ? STATUS_IN_RANGE
                                                   : STATUS_OUT_OF_RANGE;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SETTLE;
         phase_ticks_ff <= '0;
         echo_ticks_ff  <= '0;
         dist_q_ff      <= '0;
         dist_r_ff      <= '0;
         attempts_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff       <= phase_in;
            phase_ticks_ff <= phase_ticks_in;
            echo_ticks_ff  <= echo_ticks_in;
            dist_q_ff      <= dist_q_in;
            dist_r_ff      <= dist_r_in;
            attempts_ff    <= attempts_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_trigger_level_ff <= rsp_trigger_level_in;
         rsp_result_valid_ff  <= rsp_result_valid_in;
         rsp_distance_ff      <= rsp_distance_in;
         rsp_status_ff        <= rsp_status_in;
         rsp_attempt_count_ff <= attempts_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_trigger_level_ff;
   assign rsp_result_valid      = rsp_result_valid_ff;
   assign rsp_distance_centi_cm = rsp_distance_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_attempt_count     = rsp_attempt_count_ff;

endmodule

FILE: hw/rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level assertions on the echo ranger, attached by bind.
// ----------------------------------------------------------------------------
module uer_checker
   import uer_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_echo_level,
   input logic                       req_run_enable,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_trigger_level,
   input logic                       rsp_result_valid,
   input logic [15:0]                rsp_distance_centi_cm,
   input logic [1:0]                 rsp_status,
   input logic [15:0]                rsp_attempt_count,
   input logic                       csr_write_enable,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // A stalled response holds until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_trigger_level) && $stable(rsp_result_valid)
         && $stable(rsp_distance_centi_cm) && $stable(rsp_status)
         && $stable(rsp_attempt_count))
      else $error("stalled response changed");

   // The input side is only held up by a pending, stalled response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending response");

   // Ticks that end no attempt carry no distance and no status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |->
         rsp_distance_centi_cm == 16'd0 && rsp_status == STATUS_IN_RANGE)
      else $error("non-result tick carries a result");

   // Timeouts report no distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid
         && (rsp_status == STATUS_NO_RISE || rsp_status == STATUS_ECHO_LONG)
         |-> rsp_distance_centi_cm == 16'd0)
      else $error("timeout result carries a distance");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

FILE: test/ultrasonic_echo_ranger_checker.sv
// ----------------------------------------------------------------------------
// Echo ranger response checker
// Watches the tick, response and register ports of the echo ranger, keeps its
// own copy of the ranging sequencer and compares every response with it.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_checker
   import uer_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_echo_level,
   input  logic                       req_run_enable,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_trigger_level,
   input  logic                       rsp_result_valid,
   input  logic [15:0]                rsp_distance_centi_cm,
   input  logic [1:0]                 rsp_status,
   input  logic [15:0]                rsp_attempt_count,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         failures,
   output int                         pending
);

   localparam logic [DEFAULT_TICK_COUNTER_WIDTH-1:0] TICK_LIMIT = '1;
   localparam logic [DEFAULT_ECHO_COUNTER_WIDTH-1:0] ECHO_LIMIT = '1;
   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic       trigger;
      logic       result;
      logic [15:0] distance;
      status_type status;
      logic [15:0] attempts;
   } tick_response_type;

   // Register copies.
   logic [23:0] settle_limit;
   logic [9:0]  pulse_limit;
   logic [15:0] timeout_limit;
   logic [23:0] hold_limit;
   logic [15:0] lowest_centi;
   logic [15:0] highest_centi;

   // Sequencer copy.
   phase_type                              phase;
   logic [DEFAULT_TICK_COUNTER_WIDTH-1:0]  phase_count;
   logic [DEFAULT_ECHO_COUNTER_WIDTH-1:0]  echo_count;
   logic [15:0]                            attempt_total;

   tick_response_type expected_responses[$];
   int mismatch_total = 0;
   int ticks_checked = 0;

   function automatic void enter_phase(input phase_type next);
      phase = next;
      phase_count = '0;
   endfunction

   // Saturating phase counter; true once the phase has run its course.
   function automatic logic count_phase_tick(input logic [23:0] limit);
      if (phase_count != TICK_LIMIT) phase_count++;
      return (phase_count >= limit) || (phase_count == TICK_LIMIT);
   endfunction

   // One poll of an echo edge; true when the edge timeout has expired.
   function automatic logic echo_expired();
      if ((echo_count >= timeout_limit) || (echo_count == ECHO_LIMIT)) return 1'b1;
      echo_count++;
      return 1'b0;
   endfunction

   function automatic tick_response_type range_tick(input logic echo, input logic run);
      tick_response_type r;
      logic [31:0] scaled;
      logic [31:0] quotient;
      r = '0;
      case (phase)
         PH_TRIG_LOW: begin
            if (count_phase_tick(24'(LOW_GAP_TICKS))) enter_phase(PH_TRIG_HIGH);
         end
         PH_TRIG_HIGH: begin
            r.trigger = 1'b1;
            if (count_phase_tick(24'(pulse_limit))) enter_phase(PH_WAIT_RISE);
         end
         PH_WAIT_RISE: begin
            if (echo) begin
               echo_count = '0;
               if (echo_expired()) begin
                  r.result = 1'b1;
                  r.status = STATUS_ECHO_LONG;
                  enter_phase(PH_SETTLE);
               end else begin
                  enter_phase(PH_COUNT_HIGH);
               end
            end else if ((phase_count >= timeout_limit) || (phase_count == TICK_LIMIT)) begin
               r.result = 1'b1;
               r.status = STATUS_NO_RISE;
               enter_phase(PH_SETTLE);
            end else begin
               phase_count++;
            end
         end
         PH_COUNT_HIGH: begin
            if (echo) begin
               if (echo_expired()) begin
                  r.result = 1'b1;
                  r.status = STATUS_ECHO_LONG;
                  enter_phase(PH_SETTLE);
               end
            end else begin
               scaled = 32'(echo_count) * 32'(SOUND_NUM);
               quotient = scaled / 32'(SOUND_DEN);
               r.result = 1'b1;
               r.distance = (quotient > 32'(DISTANCE_SATURATE)) ? DISTANCE_SATURATE
                                                                : quotient[15:0];
               if ((scaled >= 32'(lowest_centi) * 32'(SOUND_DEN)) &&
                   (scaled <= 32'(highest_centi) * 32'(SOUND_DEN)))
                  r.status = STATUS_IN_RANGE;
               else
                  r.status = STATUS_OUT_OF_RANGE;
               enter_phase(PH_HOLD);
            end
         end
         PH_HOLD: begin
            if (count_phase_tick(hold_limit)) enter_phase(PH_SETTLE);
         end
         default: begin
            if (!run) begin
               enter_phase(PH_SETTLE);
            end else if (count_phase_tick(settle_limit)) begin
               attempt_total++;
               enter_phase(PH_TRIG_LOW);
            end
         end
      endcase
      r.attempts = attempt_total;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      if (mismatch_total < REPORT_LIMIT)
         $display("%0t: %s wrong on response %0d: got %0d, expected %0d",
                  $time, field, ticks_checked, seen, wanted);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      tick_response_type seen;
      tick_response_type wanted;
      if (reset) begin
         settle_limit  = SETTLE_TICKS_RESET;
         pulse_limit   = PULSE_TICKS_RESET;
         timeout_limit = TIMEOUT_TICKS_RESET;
         hold_limit    = HOLD_TICKS_RESET;
         lowest_centi  = MIN_DISTANCE_RESET;
         highest_centi = MAX_DISTANCE_RESET;
         enter_phase(PH_SETTLE);
         echo_count = '0;
         attempt_total = '0;
         expected_responses.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SETTLE_TICKS:  settle_limit  = csr_write_data[23:0];
               CSR_PULSE_TICKS:   pulse_limit   = csr_write_data[9:0];
               CSR_TIMEOUT_TICKS: timeout_limit = csr_write_data[15:0];
               CSR_HOLD_TICKS:    hold_limit    = csr_write_data[23:0];
               CSR_MIN_DISTANCE:  lowest_centi  = csr_write_data[15:0];
               CSR_MAX_DISTANCE:  highest_centi = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(range_tick(req_echo_level, req_run_enable));
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 32'd1, 32'd0);
            end else begin
               seen = {rsp_trigger_level, rsp_result_valid, rsp_distance_centi_cm,
                       status_type'(rsp_status), rsp_attempt_count};
               wanted = expected_responses.pop_front();
               if (seen.trigger !== wanted.trigger)
                  report_mismatch("trigger_level", 32'(seen.trigger),
                                  32'(wanted.trigger));
               if (seen.result !== wanted.result)
                  report_mismatch("result_valid", 32'(seen.result),
                                  32'(wanted.result));
               if (seen.distance !== wanted.distance)
                  report_mismatch("distance_centi_cm", 32'(seen.distance),
                                  32'(wanted.distance));
               if (seen.status !== wanted.status)
                  report_mismatch("status", 32'(seen.status), 32'(wanted.status));
               if (seen.attempts !== wanted.attempts)
                  report_mismatch("attempt_count", 32'(seen.attempts),
                                  32'(wanted.attempts));
            end
            ticks_checked++;
         end
      end
      pending  <= expected_responses.size();
      failures <= mismatch_total;
   end

endmodule

FILE: test/ultrasonic_echo_ranger_test.sv
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Drives microsecond ticks and register settings into the echo ranger and
// lets a separate checker predict and compare every response.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_test;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   // Ways in which the two sides of the block hold back traffic.
   typedef enum {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH,
      IDLE_PRESSURE
   } idle_style_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_echo_level = 1'b0;
   logic                       req_run_enable = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_trigger_level;
   logic                       rsp_result_valid;
   logic [15:0]                rsp_distance_centi_cm;
   logic [1:0]                 rsp_status;
   logic [15:0]                rsp_attempt_count;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_SETTLE_TICKS;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int failures;
   int pending;

   idle_style_type idle_style = IDLE_NONE;
   int cycles_run = 0;
   int pressure_count = 0;

   // State of the synthetic echo waveform: the current level and how many
   // more ticks it is held before it flips.
   logic echo_now = 1'b0;
   int   echo_left = 0;

   ultrasonic_echo_ranger i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_echo_level        (req_echo_level),
      .req_run_enable        (req_run_enable),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_result_valid      (rsp_result_valid),
      .rsp_distance_centi_cm (rsp_distance_centi_cm),
      .rsp_status            (rsp_status),
      .rsp_attempt_count     (rsp_attempt_count),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   ultrasonic_echo_ranger_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_echo_level        (req_echo_level),
      .req_run_enable        (req_run_enable),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_result_valid      (rsp_result_valid),
      .rsp_distance_centi_cm (rsp_distance_centi_cm),
      .rsp_status            (rsp_status),
      .rsp_attempt_count     (rsp_attempt_count),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .failures              (failures),
      .pending               (pending)
   );

   always #5 clock = ~clock;

   // The run is abandoned if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response stall generator. Under pressure the receiver holds off while the
   // pressure counter is below its threshold, so the single response register
   // fills and the block stalls the tick channel in turn.
   always @(posedge clock) begin
      pressure_count <= (pressure_count == 399) ? 0 : pressure_count + 1;
      case (idle_style)
         IDLE_RECEIVER: rsp_stall <= ($urandom_range(99) < 49);
         IDLE_BOTH:     rsp_stall <= ($urandom_range(99) < 20);
         IDLE_PRESSURE: rsp_stall <= (pressure_count < 300);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   // Offers one tick and returns in the time step of the edge at which it is
   // taken. The caller is always just past a rising edge. A sender gap is
   // only ever inserted before the tick is offered, never while it waits.
   task automatic send_tick(input logic echo, input logic run);
      while ((idle_style == IDLE_SENDER && $urandom_range(99) < 49) ||
             (idle_style == IDLE_BOTH && $urandom_range(99) < 20)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_echo_level <= echo;
      req_run_enable <= run;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_run(input logic echo, input logic run, input int count);
      repeat (count) send_tick(echo, run);
   endtask

   // Random echo waveform: alternating low and high stretches of up to span
   // ticks, so that edges land in every phase of an attempt and stretches
   // both inside and beyond the edge timeout occur. A few ticks are
   // glitched, and now and then the run enable drops.
   task automatic send_echo_ticks(input int count, input int span);
      logic level;
      repeat (count) begin
         if (echo_left == 0) begin
            echo_now = ~echo_now;
            echo_left = $urandom_range(span, 1);
         end
         echo_left--;
         level = ($urandom_range(15) == 0) ? ~echo_now : echo_now;
         send_tick(level, $urandom_range(15) != 0);
      end
   endtask

   // Stops offering ticks and waits until every response has been taken.
   // The first edge lets the checker count the last transfer before its
   // outstanding count is read.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Writes all six registers in consecutive cycles. The write enable is
   // only lowered once the last one has gone in.
   task automatic configure(input logic [23:0] settle, input logic [9:0] pulse,
                            input logic [15:0] timeout, input logic [23:0] hold,
                            input logic [15:0] lowest, input logic [15:0] highest);
      write_register(CSR_SETTLE_TICKS, settle);
      write_register(CSR_PULSE_TICKS, 24'(pulse));
      write_register(CSR_TIMEOUT_TICKS, 24'(timeout));
      write_register(CSR_HOLD_TICKS, hold);
      write_register(CSR_MIN_DISTANCE, 24'(lowest));
      write_register(CSR_MAX_DISTANCE, 24'(highest));
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [23:0] settle;
      logic [23:0] hold;
      logic [9:0]  pulse;
      logic [15:0] timeout;
      logic [15:0] lowest;
      logic [15:0] highest;
      int          span;
      int          count;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the shortest timings. The run enable is first held
      // low in settle, then one attempt measures a two tick echo, the next
      // sees no echo rise within the timeout and the third sees an echo that
      // stays high too long. Zero pulse and hold lengths act as one tick.
      configure(24'd0, 10'd0, 16'd3, 24'd0, 16'd0, 16'hFFFF);
      send_run(1'b1, 1'b0, 1);
      send_run(1'b0, 1'b1, 4);
      send_run(1'b1, 1'b1, 2);
      send_run(1'b0, 1'b1, 1);
      send_run(1'b0, 1'b0, 1);
      send_run(1'b0, 1'b1, 8);
      send_run(1'b1, 1'b1, 9);
      wait_drained();

      // A lower limit above the upper one: every measurement is out of range.
      configure(24'd0, 10'd0, 16'd1, 24'd0, 16'hFFFF, 16'd0);
      send_run(1'b0, 1'b1, 4);
      send_run(1'b1, 1'b1, 1);
      send_run(1'b0, 1'b1, 2);
      wait_drained();

      // Random part. Each phase picks its register settings and its idling
      // style while the block is drained; some phases take the extremes.
      for (int p = 0; p < 10; p++) begin
         settle  = 24'($urandom_range(6));
         pulse   = 10'($urandom_range(4));
         timeout = 16'($urandom_range(30));
         hold    = 24'($urandom_range(6));
         lowest  = 16'($urandom_range(40));
         highest = 16'($urandom_range(80));
         count   = 110;
         case (p)
            2: begin
               lowest  = 16'hFFFF;
               highest = 16'd0;
            end
            4: begin
               settle  = 24'hFFFFFF;
               pulse   = 10'd1023;
               timeout = 16'hFFFF;
               hold    = 24'hFFFFFF;
               lowest  = 16'hFFFF;
               highest = 16'hFFFF;
               count   = 40;
            end
            5: begin
               settle  = 24'd0;
               pulse   = 10'd0;
               timeout = 16'd0;
               hold    = 24'd0;
               lowest  = 16'd0;
               highest = 16'd0;
            end
            7: begin
               settle  = 24'd0;
               pulse   = 10'd1023;
               hold    = 24'd0;
            end
            9: begin
               settle  = 24'($urandom);
               pulse   = 10'($urandom);
               timeout = 16'($urandom);
               hold    = 24'($urandom);
               lowest  = 16'($urandom);
               highest = 16'($urandom);
               count   = 40;
            end
            default: ;
         endcase
         span = (timeout > 34) ? 40 : int'(timeout) + 6;
         idle_style = idle_style_type'(p % 5);
         configure(settle, pulse, timeout, hold, lowest, highest);
         send_echo_ticks(count, span);
         wait_drained();
      end

      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: ultrasonic_echo_ranger.f
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger.sv
hw/rtl/uer_checker.sv
test/ultrasonic_echo_ranger_checker.sv
test/ultrasonic_echo_ranger_test.sv
